// ===== src/tccs_pkg.sv =====
// Shared definitions for the text console engine: field widths, character
// codes, register indexes and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package tccs_pkg;

  // Default screen memory geometry.
  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 32;

  // Request and response field widths.
  localparam int CMD_W      = 1;
  localparam int CHAR_W     = 8;
  localparam int RD_COL_W   = 7;
  localparam int RD_ROW_W   = 5;
  localparam int OUT_COL_W  = 7;
  localparam int OUT_ROW_W  = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  // Character codes.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int COLS_CFG_W = 8;
  localparam int ROWS_CFG_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 6'd25;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_load;  // capture the accepted request
    logic clr_wr;     // write one blank cell of the start-up clearing pass
    logic rd_cap;     // capture the read data of a read request
    logic put_do;     // execute a put: write the cell, move the cursor
    logic cp_step;    // read one source cell of a scroll copy
    logic blk_step;   // blank one cell of the last row
    logic out_load;   // load the response register
  } tccs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_read;   // request at the input is a read
    logic clr_last;     // clearing pass is at its last cell
    logic need_scroll;  // the put in progress scrolls the screen
    logic single_row;   // only one row is in use
    logic cp_last;      // scroll copy is at its last source cell
    logic blk_last;     // blanking is at its last column
  } tccs_sts_t;

endpackage

`default_nettype wire

// ===== src/tccs_req_if.sv =====
// Request channel of the text console engine: valid/ready and the request fields.
// Depends on tccs_pkg.
`default_nettype none

interface tccs_req_if;
  import tccs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CHAR_W-1:0]   char_code;
  logic [RD_COL_W-1:0] read_col;
  logic [RD_ROW_W-1:0] read_row;

  modport source (output valid, command, char_code, read_col, read_row, input ready);
  modport sink   (input valid, command, char_code, read_col, read_row, output ready);
endinterface

`default_nettype wire

// ===== src/tccs_rsp_if.sv =====
// Response channel of the text console engine: valid/ready and the response fields.
// Depends on tccs_pkg.
`default_nettype none

interface tccs_rsp_if;
  import tccs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    read_char;
  logic [OUT_COL_W-1:0] cursor_col;
  logic [OUT_ROW_W-1:0] cursor_row;
  logic                 scrolled;

  modport source (output valid, read_char, cursor_col, cursor_row, scrolled, input ready);
  modport sink   (input valid, read_char, cursor_col, cursor_row, scrolled, output ready);
endinterface

`default_nettype wire

// ===== src/text_console_cursor_scroll_top.sv =====
// A read is captured, read from memory, its data captured and the response loaded; a put
// writes its character, unless it is a newline, and moves the cursor before that load. The
// next request is taken after the load. A scroll copies each row in use below the first one
// row up, drains the last copy write (both skipped for a single row) and blanks the last row;
// the memory writes one cell per cycle. Reset: synchronous, active low; then a clearing pass
// writes spaces to all MAX_COLS*MAX_ROWS cells (4096 by default) before any request is taken.
`default_nettype none

module text_console_cursor_scroll_top #(
  parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tccs_req_if.sink                         in_req,
  tccs_rsp_if.source                       out_rsp,
  input  logic                             cfg_we,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tccs_pkg::*;

  // The controller decides what happens in each cycle; the datapath holds the
  // cursor, the configuration, the scroll counters and the screen memory.
  tccs_cmd_t cmd;
  tccs_sts_t sts;

  // A request is taken whenever the controller is idle, even while the previous
  // response still waits in the output register; the new response is only
  // loaded once that register has been emptied.
  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Scrolls copy row by row through the memory's read port, with the matching
  // write in the following cycle, and then blank the last row in use.
  tccs_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_command     (in_req.command),
    .in_char_code   (in_req.char_code),
    .in_read_col    (in_req.read_col),
    .in_read_row    (in_req.read_row),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_read_char  (out_rsp.read_char),
    .out_cursor_col (out_rsp.cursor_col),
    .out_cursor_row (out_rsp.cursor_row),
    .out_scrolled   (out_rsp.scrolled)
  );

endmodule

`default_nettype wire

// ===== src/tccs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/tccs_ctrl.sv =====
// Controller of the text console engine: sequences clearing, reads, puts,
// scrolls and the response handshake. Depends on tccs_pkg.
`default_nettype none

module tccs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tccs_pkg::tccs_cmd_t  cmd,
  input  tccs_pkg::tccs_sts_t  sts
);
  import tccs_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_RDCAP = 9'b000001000,
    S_PUT   = 9'b000010000,
    S_SCPY  = 9'b000100000,
    S_SDRN  = 9'b001000000,
    S_SBLK  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = sts.in_is_read ? S_RD : S_PUT;
        end
      end
      S_RD: begin
        state_nxt = S_RDCAP;
      end
      S_RDCAP: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_FIN;
      end
      S_PUT: begin
        cmd.put_do = 1'b1;
        if (sts.need_scroll) begin
          state_nxt = sts.single_row ? S_SBLK : S_SCPY;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCPY: begin
        cmd.cp_step = 1'b1;
        if (sts.cp_last) begin
          state_nxt = S_SDRN;
        end
      end
      S_SDRN: begin
        state_nxt = S_SBLK;
      end
      S_SBLK: begin
        cmd.blk_step = 1'b1;
        if (sts.blk_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // An accepted request is dispatched to either the read or the put path.
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_RD || state_r == S_PUT))
    else $error("accepted request not dispatched");

  // A finished response waits while the previous one is still held.
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("response overwritten while stalled");

  // The scroll copy only ever leaves through the drain state.
  a_copy_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCPY) |=> (state_r == S_SCPY || state_r == S_SDRN))
    else $error("scroll copy left without draining");
`endif

endmodule

`default_nettype wire

// ===== src/tccs_datapath.sv =====
// Datapath of the text console engine: configuration registers, cursor,
// scroll and clearing counters, and the screen memory. Depends on tccs_pkg, tccs_ram.
`default_nettype none

module tccs_datapath #(
  parameter int MAX_COLS = tccs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tccs_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tccs_pkg::tccs_cmd_t               cmd,
  output tccs_pkg::tccs_sts_t               sts,
  input  logic [tccs_pkg::CMD_W-1:0]        in_command,
  input  logic [tccs_pkg::CHAR_W-1:0]       in_char_code,
  input  logic [tccs_pkg::RD_COL_W-1:0]     in_read_col,
  input  logic [tccs_pkg::RD_ROW_W-1:0]     in_read_row,
  input  logic                              cfg_we,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [tccs_pkg::CHAR_W-1:0]       out_read_char,
  output logic [tccs_pkg::OUT_COL_W-1:0]    out_cursor_col,
  output logic [tccs_pkg::OUT_ROW_W-1:0]    out_cursor_row,
  output logic                              out_scrolled
);
  import tccs_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                               input logic [CW-1:0] col);
    return AW'(int'(row) * MAX_COLS + int'(col));
  endfunction

  // Configuration registers and the last column and row in use.
  logic [COLS_CFG_W-1:0] cfg_cols_r;
  logic [ROWS_CFG_W-1:0] cfg_rows_r;
  logic [CW-1:0]         cols_last;
  logic [RW-1:0]         rows_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= COLS_RESET;
      cfg_rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: cfg_cols_r <= cfg_data[COLS_CFG_W-1:0];
        CFG_ROWS:    cfg_rows_r <= cfg_data[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_cols_r == '0) begin
      cols_last = '0;
    end else if (int'(cfg_cols_r) > MAX_COLS) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(cfg_cols_r - 1'b1);
    end
    if (cfg_rows_r == '0) begin
      rows_last = '0;
    end else if (int'(cfg_rows_r) > MAX_ROWS) begin
      rows_last = RW'(MAX_ROWS - 1);
    end else begin
      rows_last = RW'(cfg_rows_r - 1'b1);
    end
  end

  // Captured request.
  logic [CHAR_W-1:0]   item_char_r;
  logic [RD_COL_W-1:0] item_rcol_r;
  logic [RD_ROW_W-1:0] item_rrow_r;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_char_r <= in_char_code;
      item_rcol_r <= in_read_col;
      item_rrow_r <= in_read_row;
    end
  end

  // Cursor, clamped into the area in use before a put.
  logic [CW-1:0] cur_col_r, cur_col_nxt, cl_col;
  logic [RW-1:0] cur_row_r, cur_row_nxt, cl_row;
  logic          is_nl, at_end, row_last, need_scroll;

  always_comb begin
    cl_col      = (cur_col_r > cols_last) ? cols_last : cur_col_r;
    cl_row      = (cur_row_r > rows_last) ? rows_last : cur_row_r;
    is_nl       = (item_char_r == NEWLINE_CODE);
    at_end      = is_nl || (cl_col == cols_last);
    row_last    = (cl_row == rows_last);
    need_scroll = at_end && row_last;
    if (!at_end) begin
      cur_col_nxt = CW'(cl_col + 1'b1);
      cur_row_nxt = cl_row;
    end else if (!row_last) begin
      cur_col_nxt = '0;
      cur_row_nxt = RW'(cl_row + 1'b1);
    end else begin
      cur_col_nxt = '0;
      cur_row_nxt = cl_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else if (cmd.put_do) begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  // Scroll walker: x_r runs over the columns, y_r over the source rows.
  logic [CW-1:0] x_r;
  logic [RW-1:0] y_r;
  logic [AW-1:0] clr_cnt_r;
  logic          cp_pend_r;
  logic [AW-1:0] cp_dst_r;
  logic [AW-1:0] src_addr, dst_addr;

  assign src_addr = cell_addr(y_r, x_r);
  assign dst_addr = cell_addr(RW'(y_r - 1'b1), x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r       <= '0;
      y_r       <= '0;
      clr_cnt_r <= '0;
      cp_pend_r <= 1'b0;
    end else begin
      cp_pend_r <= cmd.cp_step;
      if (cmd.clr_wr) begin
        clr_cnt_r <= AW'(clr_cnt_r + 1'b1);
      end
      if (cmd.put_do) begin
        x_r <= '0;
        y_r <= RW'(1);
      end else if (cmd.cp_step) begin
        if (x_r == cols_last) begin
          x_r <= '0;
          y_r <= RW'(y_r + 1'b1);
        end else begin
          x_r <= CW'(x_r + 1'b1);
        end
      end else if (cmd.blk_step) begin
        x_r <= (x_r == cols_last) ? '0 : CW'(x_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cp_step) begin
      cp_dst_r <= dst_addr;
    end
  end

  // Screen memory.
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CHAR_W-1:0] wr_data, rd_data;
  logic              rd_in_range;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = BLANK_CODE;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.put_do && !is_nl) begin
      wr_en   = 1'b1;
      wr_addr = cell_addr(cl_row, cl_col);
      wr_data = item_char_r;
    end else if (cp_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = cp_dst_r;
      wr_data = rd_data;
    end else if (cmd.blk_step) begin
      wr_en   = 1'b1;
      wr_addr = cell_addr(rows_last, x_r);
    end
  end

  assign rd_in_range = (int'(item_rcol_r) < MAX_COLS) && (int'(item_rrow_r) < MAX_ROWS);
  assign rd_addr     = cmd.cp_step ? src_addr
                                   : AW'(int'(item_rrow_r) * MAX_COLS + int'(item_rcol_r));

  tccs_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Staged response and response register.
  logic [CHAR_W-1:0]    rchar_r;
  logic                 scrolled_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic                 out_scr_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_cap) begin
      rchar_r    <= rd_in_range ? rd_data : '0;
      scrolled_r <= 1'b0;
    end else if (cmd.put_do) begin
      rchar_r    <= '0;
      scrolled_r <= need_scroll;
    end
    if (cmd.out_load) begin
      out_char_r <= rchar_r;
      out_col_r  <= OUT_COL_W'(cur_col_r);
      out_row_r  <= OUT_ROW_W'(cur_row_r);
      out_scr_r  <= scrolled_r;
    end
  end

  assign out_read_char  = out_char_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_scrolled   = out_scr_r;

  always_comb begin
    sts             = '0;
    sts.in_is_read  = (in_command == CMD_READ);
    sts.clr_last    = (clr_cnt_r == AW'(DEPTH - 1));
    sts.need_scroll = need_scroll;
    sts.single_row  = (rows_last == '0);
    sts.cp_last     = (x_r == cols_last) && (y_r == rows_last);
    sts.blk_last    = (x_r == cols_last);
  end

`ifndef ASSERT_OFF
  // After a put the cursor lies inside the area that was in use.
  a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_do |=> (cur_col_r <= $past(cols_last) && cur_row_r <= $past(rows_last)))
    else $error("cursor left the area in use");

  // The delayed copy write never meets another write to the screen memory.
  a_copy_write_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cp_pend_r |-> !(cmd.blk_step || cmd.clr_wr || cmd.put_do))
    else $error("copy write collides with another write");
`endif

endmodule

`default_nettype wire
